[src/swmd_pkg.sv]
package swmd_pkg;

    // Input opcodes, carried in the slave-side tuser
    localparam logic [1:0] OP_TICK     = 2'd0;
    localparam logic [1:0] OP_WOKE     = 2'd1;
    localparam logic [1:0] OP_RESTART  = 2'd2;
    localparam logic [1:0] OP_DEFERRED = 2'd3;

    // Configuration register indexes
    localparam logic [2:0] CFG_WINDOW_MS       = 3'd0;
    localparam logic [2:0] CFG_EVENT_THRESHOLD = 3'd1;
    localparam logic [2:0] CFG_PULSE_MS        = 3'd2;
    localparam logic [2:0] CFG_IDLE_TIMEOUT_MS = 3'd3;
    localparam logic [2:0] CFG_SLEEP_ENABLE    = 3'd4;

    // Defaults, applied when a register holds zero
    localparam logic [15:0] DEF_WINDOW_MS       = 16'd2000;
    localparam logic [5:0]  DEF_EVENT_THRESHOLD = 6'd3;
    localparam logic [15:0] DEF_PULSE_MS        = 16'd500;
    localparam logic [23:0] DEF_IDLE_TIMEOUT_MS = 24'd10000;

    // Green wake pulse length
    localparam logic [15:0] GREEN_PULSE_MS = 16'd150;

    // Per-cell control: move the neighbor's time in, or load a new time
    typedef struct packed {
        logic shift;
        logic load;
    } t_cell_ctl;

endpackage

[src/swmd_cell.sv]
module swmd_cell
    import swmd_pkg::*;
#(
    parameter int TIME_BITS = 32
) (
    input  logic                 i_clk,
    input  t_cell_ctl            i_ctl,
    input  logic [TIME_BITS-1:0] i_load_time,
    input  logic [TIME_BITS-1:0] i_next_time,
    output logic [TIME_BITS-1:0] o_time
);

    logic [TIME_BITS-1:0] r_time;

    // Load wins over shift so a full-ring insert lands in the tail cell
    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_time <= i_load_time;
        end else if (i_ctl.shift) begin
            r_time <= i_next_time;
        end
    end

    assign o_time = r_time;

endmodule

[src/swmd_chain.sv]
module swmd_chain
    import swmd_pkg::*;
#(
    parameter int EVENT_SLOTS = 32,
    parameter int TIME_BITS   = 32,
    parameter int IDX_BITS    = 5
) (
    input  logic                 i_clk,
    input  logic                 i_shift,
    input  logic                 i_load,
    input  logic [IDX_BITS-1:0]  i_load_idx,
    input  logic [TIME_BITS-1:0] i_load_time,
    output logic [TIME_BITS-1:0] o_head_time
);

    logic [TIME_BITS-1:0] w_time [EVENT_SLOTS];
    t_cell_ctl            w_ctl  [EVENT_SLOTS];

    genvar g;
    generate
        for (g = 0; g < EVENT_SLOTS; g++) begin : g_cell
            logic [TIME_BITS-1:0] w_next;

            // Decode the load slot; the tail cell has no neighbor to take from
            assign w_ctl[g].shift = i_shift;
            assign w_ctl[g].load  = i_load && (i_load_idx == IDX_BITS'(g));

            if (g == EVENT_SLOTS - 1) begin : g_tail
                assign w_next = w_time[g];
            end else begin : g_body
                assign w_next = w_time[g+1];
            end

            swmd_cell #(
                .TIME_BITS(TIME_BITS)
            ) u_cell (
                .i_clk      (i_clk),
                .i_ctl      (w_ctl[g]),
                .i_load_time(i_load_time),
                .i_next_time(w_next),
                .o_time     (w_time[g])
            );
        end
    endgenerate

    // Cell zero always holds the oldest stored time
    assign o_head_time = w_time[0];

endmodule

[src/sliding_window_motion_detector_core.sv]
// Sliding-window motion detector. Interrupt times are kept oldest first in a
// row of EVENT_SLOTS cells that shift toward cell zero; a full row drops its
// oldest time when a new one comes in. A tick request (opcode 0) stores the
// interrupt when accepted, then evicts expired times at the head cell one at
// a time (at most EVENT_SLOTS of them), sees that the head is still in the
// window, and settles the latch, pulses and sleep request before the next
// request can be accepted. Wake, restart and defer requests finish in the
// cycle they are accepted. Results sit in an output register; a request is
// taken only when that register is free or being read. Configuration writes
// are always ready and a register of zero selects its default.
module sliding_window_motion_detector_core
    import swmd_pkg::*;
#(
    parameter int EVENT_SLOTS = 32,
    parameter int TIME_BITS   = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // slave side
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [39:0] i_s_tdata,  // [31:0] now_ms, [32] irq_event, rest zero
    input  logic [1:0]  i_s_tuser,  // [1:0] opcode
    // master side
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [15:0] o_m_tdata,  // [5:0] window_count, [6] detect_fired,
                                    // [7] red_on, [8] green_on,
                                    // [9] sleep_request, rest zero
    // configuration
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [23:0] i_cfg_data
);

    localparam int IDX_BITS = (EVENT_SLOTS > 1) ? $clog2(EVENT_SLOTS) : 1;
    localparam int CNT_BITS = $clog2(EVENT_SLOTS + 1);
    localparam int CMP_BITS = (CNT_BITS > 6) ? CNT_BITS : 6;
    localparam int NOW_EXT  = (TIME_BITS > 32) ? TIME_BITS : 32;
    localparam int TO_BITS  = (TIME_BITS > 24) ? TIME_BITS : 24;

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_EVICT  = 2'd1;
    localparam logic [1:0] S_FINISH = 2'd2;

    // Configuration registers
    logic [15:0] r_window_ms;
    logic [5:0]  r_threshold;
    logic [15:0] r_pulse_ms;
    logic [23:0] r_idle_timeout;
    logic        r_sleep_en;

    // Control and detector state
    logic [1:0]           r_state,      n_state;
    logic [CNT_BITS-1:0]  r_count,      n_count;
    logic                 r_latch,      n_latch;
    logic [TIME_BITS-1:0] r_last_det,   n_last_det;
    logic [TIME_BITS-1:0] r_red_end,    n_red_end;
    logic                 r_red,        n_red;
    logic [TIME_BITS-1:0] r_green_end,  n_green_end;
    logic                 r_green,      n_green;
    logic [TIME_BITS-1:0] r_now,        n_now;
    logic                 r_out_valid,  n_out_valid;
    logic [15:0]          r_out_data,   n_out_data;

    logic                 w_accept;
    logic [NOW_EXT-1:0]   w_now_ext;
    logic [TIME_BITS-1:0] w_now;
    logic                 w_irq;
    logic [TIME_BITS-1:0] w_head_time;
    logic [TIME_BITS-1:0] w_win;
    logic [TIME_BITS-1:0] w_pulse;
    logic [CMP_BITS-1:0]  w_thr;
    logic [TO_BITS-1:0]   w_timeout;
    logic                 w_full;
    logic                 w_evict;
    logic                 w_shift;
    logic                 w_load;
    logic [IDX_BITS-1:0]  w_load_idx;
    logic                 w_fired;
    logic                 w_sleep_req;

    assign w_accept  = i_s_tvalid && o_s_tready;
    assign w_now_ext = NOW_EXT'(i_s_tdata[31:0]);
    assign w_now     = w_now_ext[TIME_BITS-1:0];
    assign w_irq     = i_s_tdata[32];

    // Pick defaults for zero registers
    assign w_win     = TIME_BITS'((r_window_ms == '0) ? DEF_WINDOW_MS : r_window_ms);
    assign w_pulse   = TIME_BITS'((r_pulse_ms == '0) ? DEF_PULSE_MS : r_pulse_ms);
    assign w_thr     = CMP_BITS'((r_threshold == '0) ? DEF_EVENT_THRESHOLD : r_threshold);
    assign w_timeout = TO_BITS'((r_idle_timeout == '0) ? DEF_IDLE_TIMEOUT_MS
                                                       : r_idle_timeout);

    assign w_full     = (r_count == CNT_BITS'(EVENT_SLOTS));
    assign w_evict    = (r_state == S_EVICT) && (r_count != '0)
                     && ((r_now - w_head_time) > w_win);
    assign w_load     = w_accept && (i_s_tuser == OP_TICK) && w_irq;
    assign w_shift    = (w_load && w_full) || w_evict;
    assign w_load_idx = w_full ? IDX_BITS'(EVENT_SLOTS - 1) : r_count[IDX_BITS-1:0];

    swmd_chain #(
        .EVENT_SLOTS(EVENT_SLOTS),
        .TIME_BITS  (TIME_BITS),
        .IDX_BITS   (IDX_BITS)
    ) u_chain (
        .i_clk      (i_clk),
        .i_shift    (w_shift),
        .i_load     (w_load),
        .i_load_idx (w_load_idx),
        .i_load_time(w_now),
        .o_head_time(w_head_time)
    );

    // Request and result control
    always_comb begin
        logic [CMP_BITS-1:0] v_count;
        logic [TO_BITS-1:0]  v_idle;
        n_state     = r_state;
        n_count     = r_count;
        n_latch     = r_latch;
        n_last_det  = r_last_det;
        n_red_end   = r_red_end;
        n_red       = r_red;
        n_green_end = r_green_end;
        n_green     = r_green;
        n_now       = r_now;
        n_out_valid = r_out_valid;
        n_out_data  = r_out_data;
        w_fired     = 1'b0;
        w_sleep_req = 1'b0;
        v_count     = CMP_BITS'(r_count);
        v_idle      = '0;

        // Drop the result once taken
        if (r_out_valid && i_m_tready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_now = w_now;
                    unique case (i_s_tuser)
                        OP_TICK: begin
                            if (w_irq && !w_full) begin
                                n_count = r_count + CNT_BITS'(1);
                            end
                            n_state = S_EVICT;
                        end
                        OP_WOKE: begin
                            n_last_det  = w_now;
                            n_count     = '0;
                            n_latch     = 1'b0;
                            n_red       = 1'b0;
                            n_green     = 1'b1;
                            n_green_end = w_now + TIME_BITS'(GREEN_PULSE_MS);
                        end
                        OP_RESTART: begin
                            n_last_det = w_now;
                            n_count    = '0;
                            n_latch    = 1'b0;
                        end
                        default: begin
                            n_last_det = w_now;
                        end
                    endcase
                    if (i_s_tuser != OP_TICK) begin
                        v_count     = CMP_BITS'(n_count);
                        n_out_valid = 1'b1;
                        n_out_data  = {6'd0, 1'b0, n_green, n_red, 1'b0, v_count[5:0]};
                    end
                end
            end
            S_EVICT: begin
                // Advance the row one slot per expired head
                if (w_evict) begin
                    n_count = r_count - CNT_BITS'(1);
                end else begin
                    n_state = S_FINISH;
                end
            end
            S_FINISH: begin
                if (v_count >= w_thr) begin
                    if (!r_latch) begin
                        n_latch    = 1'b1;
                        n_last_det = r_now;
                        n_red      = 1'b1;
                        n_red_end  = r_now + w_pulse;
                        w_fired    = 1'b1;
                    end
                end else begin
                    n_latch = 1'b0;
                end
                if (n_red && (r_now >= n_red_end)) begin
                    n_red = 1'b0;
                end
                if (r_green && (r_now >= r_green_end)) begin
                    n_green = 1'b0;
                end
                v_idle = TO_BITS'(TIME_BITS'(r_now - n_last_det));
                if (r_sleep_en && (v_idle >= w_timeout)) begin
                    w_sleep_req = 1'b1;
                end
                n_out_valid = 1'b1;
                n_out_data  = {6'd0, w_sleep_req, n_green, n_red, w_fired, v_count[5:0]};
                n_state     = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_latch     <= 1'b0;
            r_last_det  <= '0;
            r_red_end   <= '0;
            r_red       <= 1'b0;
            r_green_end <= '0;
            r_green     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_latch     <= n_latch;
            r_last_det  <= n_last_det;
            r_red_end   <= n_red_end;
            r_red       <= n_red;
            r_green_end <= n_green_end;
            r_green     <= n_green;
            r_out_valid <= n_out_valid;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_now      <= n_now;
        r_out_data <= n_out_data;
    end

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window_ms    <= DEF_WINDOW_MS;
            r_threshold    <= DEF_EVENT_THRESHOLD;
            r_pulse_ms     <= DEF_PULSE_MS;
            r_idle_timeout <= DEF_IDLE_TIMEOUT_MS;
            r_sleep_en     <= 1'b0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_WINDOW_MS:       r_window_ms    <= i_cfg_data[15:0];
                CFG_EVENT_THRESHOLD: r_threshold    <= i_cfg_data[5:0];
                CFG_PULSE_MS:        r_pulse_ms     <= i_cfg_data[15:0];
                CFG_IDLE_TIMEOUT_MS: r_idle_timeout <= i_cfg_data;
                CFG_SLEEP_ENABLE:    r_sleep_en     <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    assign o_s_tready  = (r_state == S_IDLE) && (!r_out_valid || i_m_tready);
    assign o_cfg_ready = 1'b1;
    assign o_m_tvalid  = r_out_valid;
    assign o_m_tdata   = r_out_data;

endmodule
